// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue package
// Shared constants, codes and types for the timer queue and its cells.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    // Number of cells in the queue and the cap on expiries emitted by one tick.
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int EMIT_W      = $clog2(MAX_RESULTS);

    localparam logic [15:0] DEFAULT_DELAY_RESET = 16'd10;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ADDED        = 3'd0,
        KIND_REJECTED     = 3'd1,
        KIND_DELETED      = 3'd2,
        KIND_NOT_FOUND    = 3'd3,
        KIND_EXPIRED      = 3'd4,
        KIND_NONE_EXPIRED = 3'd5
    } kind_t;

    // Command broadcast to every cell.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SHIFT  = 2'd3
    } cell_cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_EXEC    = 2'd1,
        ST_SUMMARY = 2'd2,
        ST_EMIT    = 2'd3
    } state_t;

    // One queue entry.
    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] ident;
    } entry_t;

    // Values shared by all cells in a cycle.
    typedef struct packed {
        cell_cmd_t   cmd;
        logic [31:0] now;
        logic [15:0] delay;
        logic [15:0] tid;
    } cell_bus_t;

endpackage

// ===== design/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell
// Holds one entry, compares it against the broadcast time and operands, and
// loads the new entry or the entry of its left or right neighbor to insert or remove an entry.
// ----------------------------------------------------------------------------
module sdtq_cell
    import sdtq_pkg::*;
(
    input  logic        clk,
    input  cell_bus_t   bus,
    input  logic        occupied,
    input  entry_t      new_entry,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    input  logic        left_gt,
    input  logic        match_in,
    output logic        gt,
    output logic        match_out,
    output logic        expired,
    output logic [15:0] time_left,
    output entry_t      entry
);

    entry_t      entry_reg;
    entry_t      entry_next;
    logic [31:0] gap;
    logic        own_match;

    // Distance from the current time to this entry's deadline.
    assign gap = entry_reg.deadline - bus.now;

    // An empty cell counts as later than any new deadline.
    assign gt = !occupied || ($signed(gap) > $signed({16'd0, bus.delay}));

    assign own_match = occupied && (entry_reg.ident == bus.tid) && (bus.tid != 16'd0);
    assign match_out = match_in || own_match;

    assign expired = occupied && (gap[31] || (gap == 32'd0));

    // Distance clamped to the 16-bit result range.
    always_comb
    begin
        if (gap[31])
        begin
            time_left = 16'd0;
        end
        else if (|gap[31:16])
        begin
            time_left = 16'hFFFF;
        end
        else
        begin
            time_left = gap[15:0];
        end
    end

    // Choose where this cell loads from.
    always_comb
    begin
        entry_next = entry_reg;
        case (bus.cmd)
            CMD_INSERT:
            begin
                if (gt)
                begin
                    entry_next = left_gt ? left_entry : new_entry;
                end
            end
            CMD_DELETE:
            begin
                if (match_out)
                begin
                    entry_next = right_entry;
                end
            end
            CMD_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Keeps timer tasks sorted by deadline in a row of cells and reports adds,
// deletes and expiries on a result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser carries the operation (add, delete,
//   tick), tdata the delay and the task id. Result items leave on m_axis:
//   tuser is the kind, tdata the id, empty flag and time to next deadline,
//   and tlast marks the final result of one input item.
//   Add and delete pass from acceptance through ST_EXEC, which updates the
//   row of cells, and ST_SUMMARY, which reads the new head and loads the
//   result. A tick with expiries runs ST_EMIT, one shift per expiry. The
//   controller works on one item at a time and is ready again in the cycle
//   after the last result is loaded, so it takes no new item before the
//   last one is through. An input with operation 3 is dropped.
//   The result sits in an output register: the next item can be accepted
//   while it waits. A stalled receiver holds the expiry sequence, one shift
//   per result taken.
//   Reset clears the time, id counter and entry count and loads the default
//   delay with 10; no clearing pass over the cells is needed. Use cfg_wr_en,
//   which writes default_delay, only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // delay [15:0], task_id [31:16]
    input  logic [1:0]  s_axis_tuser,   // operation [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_id [15:0], queue_empty [16],
                                        // time_to_next [32:17], zero [39:33]
    output logic [2:0]  m_axis_tuser,   // kind [2:0]
    output logic        m_axis_tlast
);

    state_t             state_reg, state_next;
    logic [15:0]        default_delay_reg;
    logic [31:0]        now_reg, now_next;
    logic [15:0]        id_counter_reg, id_counter_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [EMIT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    op_t                op_reg, op_next;
    logic [15:0]        delay_reg, delay_next;
    logic [15:0]        tid_reg, tid_next;
    kind_t              res_kind_reg, res_kind_next;
    logic [15:0]        res_id_reg, res_id_next;
    logic               sum_empty_reg, sum_empty_next;
    logic [15:0]        sum_ttn_reg, sum_ttn_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [15:0]        out_id_reg, out_id_next;
    logic               out_empty_reg, out_empty_next;
    logic [15:0]        out_ttn_reg, out_ttn_next;
    logic               out_last_reg, out_last_next;

    logic               in_accept;
    logic               out_free;
    logic               full;
    logic [15:0]        eff_delay;
    logic [15:0]        id_inc;
    entry_t             new_entry;
    cell_bus_t          bus;

    logic [QUEUE_DEPTH-1:0] occupied;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] match_chain;
    logic [QUEUE_DEPTH-1:0] expired;
    logic [QUEUE_DEPTH-1:0] removed;
    logic [QUEUE_DEPTH-1:0] head;
    logic [15:0]            time_left [QUEUE_DEPTH];
    entry_t                 entries   [QUEUE_DEPTH];
    logic                   head_empty;
    logic [15:0]            head_ttn;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign full          = (count_reg == COUNT_W'(QUEUE_DEPTH));

    // Delay of zero selects the default, and a zero default counts as one.
    always_comb
    begin
        if (s_axis_tdata[15:0] != 16'd0)
        begin
            eff_delay = s_axis_tdata[15:0];
        end
        else if (default_delay_reg != 16'd0)
        begin
            eff_delay = default_delay_reg;
        end
        else
        begin
            eff_delay = 16'd1;
        end
    end

    // Ids run from 1 to 65535 and wrap back to 1.
    assign id_inc = (id_counter_reg == 16'hFFFF) ? 16'd1 : (id_counter_reg + 16'd1);

    assign new_entry.deadline = now_reg + {16'd0, delay_reg};
    assign new_entry.ident    = id_counter_reg;

    // Row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic   left_gt_w;
            logic   match_in_w;
            entry_t left_w;
            entry_t right_w;

            assign occupied[gi] = (COUNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_gt_w  = 1'b0;
                assign match_in_w = 1'b0;
                assign left_w     = new_entry;
            end
            else
            begin : g_rest
                assign left_gt_w  = gt[gi-1];
                assign match_in_w = match_chain[gi-1];
                assign left_w     = entries[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_end
                assign right_w = entries[gi];
            end
            else
            begin : g_mid
                assign right_w = entries[gi+1];
            end

            sdtq_cell u_cell (
                .clk         (clk),
                .bus         (bus),
                .occupied    (occupied[gi]),
                .new_entry   (new_entry),
                .left_entry  (left_w),
                .right_entry (right_w),
                .left_gt     (left_gt_w),
                .match_in    (match_in_w),
                .gt          (gt[gi]),
                .match_out   (match_chain[gi]),
                .expired     (expired[gi]),
                .time_left   (time_left[gi]),
                .entry       (entries[gi])
            );

            // Entries one tick would remove, and the head that remains.
            assign removed[gi] = expired[gi] && (gi < MAX_RESULTS);
            if (gi == 0)
            begin : g_head_first
                assign head[gi] = occupied[gi] && !removed[gi];
            end
            else
            begin : g_head_rest
                assign head[gi] = occupied[gi] && !removed[gi] && removed[gi-1];
            end
        end
    endgenerate

    // Select the time to the earliest deadline left in the queue.
    always_comb
    begin
        head_ttn = 16'd0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            head_ttn = head_ttn | (head[i] ? time_left[i] : 16'd0);
        end
    end
    assign head_empty = !(|head);

    // Controller: next state, cell command and result loading.
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        id_counter_next = id_counter_reg;
        count_next      = count_reg;
        emit_cnt_next   = emit_cnt_reg;
        op_next         = op_reg;
        delay_next      = delay_reg;
        tid_next        = tid_reg;
        res_kind_next   = res_kind_reg;
        res_id_next     = res_id_reg;
        sum_empty_next  = sum_empty_reg;
        sum_ttn_next    = sum_ttn_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_empty_next  = out_empty_reg;
        out_ttn_next    = out_ttn_reg;
        out_last_next   = out_last_reg;
        bus.cmd         = CMD_HOLD;
        bus.now         = now_reg;
        bus.delay       = delay_reg;
        bus.tid         = tid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = op_t'(s_axis_tuser);
                    delay_next = eff_delay;
                    tid_next   = s_axis_tdata[31:16];
                    if (op_t'(s_axis_tuser) == OP_ADD)
                    begin
                        id_counter_next = id_inc;
                    end
                    if (op_t'(s_axis_tuser) != OP_NONE)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                state_next = ST_SUMMARY;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (full)
                        begin
                            res_kind_next = KIND_REJECTED;
                            res_id_next   = 16'd0;
                        end
                        else
                        begin
                            bus.cmd       = CMD_INSERT;
                            count_next    = count_reg + COUNT_W'(1);
                            res_kind_next = KIND_ADDED;
                            res_id_next   = id_counter_reg;
                        end
                    end
                    OP_DELETE:
                    begin
                        bus.cmd = CMD_DELETE;
                        if (match_chain[QUEUE_DEPTH-1])
                        begin
                            count_next    = count_reg - COUNT_W'(1);
                            res_kind_next = KIND_DELETED;
                            res_id_next   = tid_reg;
                        end
                        else
                        begin
                            res_kind_next = KIND_NOT_FOUND;
                            res_id_next   = 16'd0;
                        end
                    end
                    default:
                    begin
                        now_next      = now_reg + 32'd1;
                        res_kind_next = KIND_NONE_EXPIRED;
                        res_id_next   = 16'd0;
                    end
                endcase
            end

            ST_SUMMARY:
            begin
                sum_empty_next = head_empty;
                sum_ttn_next   = head_ttn;
                if ((op_reg == OP_TICK) && removed[0])
                begin
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_id_next    = res_id_reg;
                    out_empty_next = head_empty;
                    out_ttn_next   = head_ttn;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    bus.cmd        = CMD_SHIFT;
                    count_next     = count_reg - COUNT_W'(1);
                    emit_cnt_next  = emit_cnt_reg + EMIT_W'(1);
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EXPIRED;
                    out_id_next    = entries[0].ident;
                    out_empty_next = sum_empty_reg;
                    out_ttn_next   = sum_ttn_reg;
                    out_last_next  = !expired[1] || (emit_cnt_reg == EMIT_W'(MAX_RESULTS - 1));
                    if (out_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            default_delay_reg <= DEFAULT_DELAY_RESET;
            now_reg           <= 32'd0;
            id_counter_reg    <= 16'd0;
            count_reg         <= '0;
            emit_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            id_counter_reg <= id_counter_next;
            count_reg      <= count_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                default_delay_reg <= cfg_wr_data;
            end
        end
    end

    // Operand and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        delay_reg     <= delay_next;
        tid_reg       <= tid_next;
        res_kind_reg  <= res_kind_next;
        res_id_reg    <= res_id_next;
        sum_empty_reg <= sum_empty_next;
        sum_ttn_reg   <= sum_ttn_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_empty_reg <= out_empty_next;
        out_ttn_reg   <= out_ttn_next;
        out_last_reg  <= out_last_next;
    end

    // Result stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_ttn_reg, out_empty_reg, out_id_reg};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted deadline timer queue
// Drives add, delete and tick items into the block. A predictor in this file
// tracks the timer list and the clock, and a checker compares every result
// item field by field with the oldest predicted one. The tests run in turn:
// basic operations, a full queue with equal deadlines, default delay
// extremes, and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import sdtq_pkg::*;

    // Cycles to let pass after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 24;

    // One predicted result item.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] ident;
        logic        empty;
        logic [15:0] ttn;
        logic        last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;   // delay [15:0], task_id [31:16]
    logic [1:0]  s_axis_tuser = OP_NONE; // operation [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // result_id [15:0], queue_empty [16],
                                         // time_to_next [32:17], zero [39:33]
    logic [2:0]  m_axis_tuser;           // kind [2:0]
    logic        m_axis_tlast;

    // Predicted state of the timer list.
    logic [31:0]   clock_secs = 32'd0;
    logic [15:0]   last_id = 16'd0;
    logic [15:0]   dflt_delay = DEFAULT_DELAY_RESET;
    entry_t        timers[$];
    timer_result_t pending_results[$];

    int            error_count = 0;
    bit            gaps_on = 1'b1;
    bit            stall_on = 1'b1;
    timer_result_t want_r;

    sorted_deadline_timer_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random back-pressure on the result side.
    always @(posedge clk)
    begin
        m_axis_tready <= stall_on ? ($urandom_range(99) >= 38) : 1'b1;
    end

    // Signed distance from the current second to a deadline, modulo 2^32.
    function automatic longint deadline_gap(input logic [31:0] dl);
        logic [31:0] diff;
        diff = dl - clock_secs;
        return longint'($signed(diff));
    endfunction

    // Update the timer list for one accepted item and queue its results.
    function automatic void predict_step(input op_t op, input logic [15:0] dly,
                                         input logic [15:0] tid);
        timer_result_t batch[$];
        timer_result_t r;
        entry_t        e;
        logic [15:0]   eff;
        logic [15:0]   ttn;
        longint        gap;
        int            pos;
        int            i;
        bit            hit;
        r = '0;
        hit = 1'b0;
        case (op)
            OP_ADD:
            begin
                last_id = last_id + 16'd1;
                if (last_id == 16'd0)
                    last_id = 16'd1;
                if (timers.size() >= QUEUE_DEPTH)
                begin
                    r.kind = KIND_REJECTED;
                    r.ident = 16'd0;
                end
                else
                begin
                    eff = (dly != 16'd0) ? dly : ((dflt_delay != 16'd0) ? dflt_delay : 16'd1);
                    e.deadline = clock_secs + {16'd0, eff};
                    e.ident = last_id;
                    // Insert ahead of the first strictly later deadline.
                    pos = timers.size();
                    for (i = 0; i < timers.size() && !hit; i++)
                    begin
                        if (deadline_gap(timers[i].deadline) > deadline_gap(e.deadline))
                        begin
                            pos = i;
                            hit = 1'b1;
                        end
                    end
                    timers.insert(pos, e);
                    r.kind = KIND_ADDED;
                    r.ident = last_id;
                end
                batch.push_back(r);
            end
            OP_DELETE:
            begin
                for (i = 0; i < timers.size() && !hit; i++)
                begin
                    if (timers[i].ident == tid)
                    begin
                        timers.delete(i);
                        hit = 1'b1;
                    end
                end
                r.kind = hit ? KIND_DELETED : KIND_NOT_FOUND;
                r.ident = hit ? tid : 16'd0;
                batch.push_back(r);
            end
            OP_TICK:
            begin
                clock_secs = clock_secs + 32'd1;
                i = 0;
                while (i < timers.size() && batch.size() < MAX_RESULTS)
                begin
                    if (deadline_gap(timers[i].deadline) <= 0)
                    begin
                        r.kind = KIND_EXPIRED;
                        r.ident = timers[i].ident;
                        batch.push_back(r);
                        timers.delete(i);
                    end
                    else
                        i++;
                end
                if (batch.size() == 0)
                begin
                    r.kind = KIND_NONE_EXPIRED;
                    r.ident = 16'd0;
                    batch.push_back(r);
                end
            end
            default:
                return;
        endcase

        // Every result of the step carries the state after the whole step.
        ttn = 16'd0;
        if (timers.size() != 0)
        begin
            gap = deadline_gap(timers[0].deadline);
            if (gap < 0)
                ttn = 16'd0;
            else if (gap > 65535)
                ttn = 16'hFFFF;
            else
                ttn = 16'(gap);
        end
        for (i = 0; i < batch.size(); i++)
        begin
            r = batch[i];
            r.empty = (timers.size() == 0);
            r.ttn = ttn;
            r.last = (i == batch.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= 100)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Compare each result item with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result kind", m_axis_tuser, -1);
            else
            begin
                want_r = pending_results.pop_front();
                if (m_axis_tuser !== want_r.kind)
                    report_mismatch("kind", m_axis_tuser, want_r.kind);
                if (m_axis_tdata[15:0] !== want_r.ident)
                    report_mismatch("result_id", m_axis_tdata[15:0], want_r.ident);
                if (m_axis_tdata[16] !== want_r.empty)
                    report_mismatch("queue_empty", m_axis_tdata[16], want_r.empty);
                if (m_axis_tdata[32:17] !== want_r.ttn)
                    report_mismatch("time_to_next", m_axis_tdata[32:17], want_r.ttn);
                if (m_axis_tdata[39:33] !== 7'd0)
                    report_mismatch("padding", m_axis_tdata[39:33], 0);
                if (m_axis_tlast !== want_r.last)
                    report_mismatch("tlast", m_axis_tlast, want_r.last);
            end
        end
    end

    // Send one item; valid stays high afterwards so back-to-back items need
    // no second assignment in the same step.
    task automatic send_item(input op_t op, input logic [15:0] dly, input logic [15:0] tid);
        while (gaps_on && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {tid, dly};
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_step(op, dly, tid);
    endtask

    // Hold the input until every predicted result has arrived and the block settles.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_delay(input logic [15:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dflt_delay = value;
    endtask

    // Delete every held task, head first.
    task automatic clear_queue();
        while (timers.size() != 0)
            send_item(OP_DELETE, 16'($urandom), timers[0].ident);
    endtask

    // Field extremes, every operation, dropped items and lookups that miss.
    task automatic test_basic_operations();
        int i;
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_ADD, 16'h0000, 16'hFFFF);
        send_item(OP_ADD, 16'hFFFF, 16'h0000);
        send_item(OP_ADD, 16'h0001, 16'h5A5A);
        send_item(OP_ADD, 16'h0003, 16'hA5A5);
        send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
        send_item(OP_DELETE, 16'hFFFF, 16'h0000);
        send_item(OP_DELETE, 16'h0000, 16'hFFFF);
        send_item(OP_DELETE, 16'h1234, 16'd4);
        send_item(OP_NONE, 16'h0000, 16'h0000);
        // The one-second task goes at the first tick, the default one at the tenth.
        for (i = 0; i < 11; i++)
            send_item(OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // Sixteen equal deadlines keep insertion order and all expire in one tick.
    task automatic test_full_queue();
        int i;
        write_default_delay(16'd5);
        clear_queue();
        send_item(OP_DELETE, 16'd0, 16'd1);
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_item(OP_ADD, (i % 2 == 0) ? 16'd0 : 16'd5, 16'($urandom));
        send_item(OP_ADD, 16'd2, 16'($urandom));
        for (i = 0; i < 6; i++)
            send_item(OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // A zero default acts as one second; the largest default drives time_to_next to its top value.
    task automatic test_default_extremes();
        write_default_delay(16'd0);
        send_item(OP_ADD, 16'd0, 16'($urandom));
        send_item(OP_TICK, 16'($urandom), 16'($urandom));
        write_default_delay(16'hFFFF);
        send_item(OP_ADD, 16'd0, 16'($urandom));
        send_item(OP_ADD, 16'hFFFE, 16'($urandom));
        send_item(OP_DELETE, 16'($urandom), last_id);
        send_item(OP_TICK, 16'($urandom), 16'($urandom));
        write_default_delay(16'd1);
    endtask

    // Mixed traffic in four phases with different default delays.
    task automatic test_random_traffic();
        logic [15:0] phase_delay [4];
        logic [15:0] dly;
        logic [15:0] tid;
        int          phase;
        int          sent;
        int          pick;
        int          shape;
        phase_delay = '{16'd4, 16'd1, 16'd2, 16'hFFFF};
        for (phase = 0; phase < 4; phase++)
        begin
            write_default_delay(phase_delay[phase]);
            // The second phase runs with no idling on either side.
            gaps_on = (phase != 1);
            stall_on = (phase != 1);
            sent = 0;
            while (sent < 95)
            begin
                pick = $urandom_range(99);
                dly = 16'($urandom);
                tid = 16'($urandom);
                if (pick < 5)
                    send_item(OP_NONE, dly, tid);
                else
                begin
                    sent++;
                    if (pick < 45)
                    begin
                        // Mostly short delays so tasks expire within the run.
                        shape = $urandom_range(9);
                        if (shape < 6)
                            dly = 16'($urandom_range(1, 12));
                        else if (shape < 8)
                            dly = 16'd0;
                        else if (shape < 9)
                            dly = 16'($urandom_range(13, 400));
                        send_item(OP_ADD, dly, tid);
                    end
                    else if (pick < 80)
                        send_item(OP_TICK, dly, tid);
                    else
                    begin
                        if (timers.size() != 0 && $urandom_range(9) < 7)
                            tid = timers[$urandom_range(timers.size() - 1)].ident;
                        send_item(OP_DELETE, dly, tid);
                    end
                    if ($urandom_range(99) < 3)
                        drain_results();
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_operations();
        test_full_queue();
        test_default_extremes();
        test_random_traffic();
        drain_results();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sorted_deadline_timer_queue.f =====
design/sdtq_pkg.sv
design/sdtq_cell.sv
design/sorted_deadline_timer_queue.sv
test/tb_top.sv
